@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, switched off while reset is high
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mme_pkg.sv @@
// types, constants and codes of the matrix multiply engine
`default_nettype none

package mme_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 6;
  localparam int DIM_W  = 4;
  localparam int POS_W  = 3;
  localparam int PROD_W = 35;
  localparam int REG_W  = 2;
  localparam int OUT_W  = ((PROD_W + 2 * POS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A  = 2'd0,
    CMD_WR_B  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef enum logic [REG_W-1:0] {
    REG_NUM_ROWS  = 2'd0,
    REG_INNER_LEN = 2'd1,
    REG_NUM_COLS  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             issue;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] a_addr;
    logic [IDX_W-1:0] b_addr;
    logic             load_out;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             is_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/mme_ctrl.sv @@
// controller: configuration registers, loop counters and sequencing state machine
`default_nettype none

module mme_ctrl #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mme_pkg::REG_W-1:0]   cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]   cfg_data,
  input  logic                        in_accept,
  input  logic [mme_pkg::CMD_W-1:0]   command,
  output logic                        in_ready,
  output mme_pkg::dp_cmd_t            cmd,
  input  mme_pkg::dp_status_t         status
);

  localparam logic [mme_pkg::DIM_W-1:0] MaxDim = mme_pkg::DIM_W'(MAX_DIM);

  logic [mme_pkg::DIM_W-1:0] num_rows, inner_len, num_cols;
  logic [mme_pkg::DIM_W-1:0] rows_c, inner_c, cols_c;

  mme_pkg::state_t state, state_next;

  logic [mme_pkg::POS_W-1:0] row_cnt, row_cnt_next;
  logic [mme_pkg::POS_W-1:0] col_cnt, col_cnt_next;
  logic [mme_pkg::POS_W-1:0] k_cnt, k_cnt_next;
  logic [mme_pkg::IDX_W-1:0] a_base, a_base_next;
  logic [mme_pkg::IDX_W-1:0] b_base, b_base_next;

  logic k_last, row_last, col_last;

  function automatic logic [mme_pkg::DIM_W-1:0] clamp_dim(input logic [mme_pkg::DIM_W-1:0] v);
    logic [mme_pkg::DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = mme_pkg::DIM_W'(1);
    end else if (v > MaxDim) begin
      r = MaxDim;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= MaxDim;
      inner_len <= MaxDim;
      num_cols  <= MaxDim;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mme_pkg::REG_NUM_ROWS:  num_rows  <= cfg_data;
        mme_pkg::REG_INNER_LEN: inner_len <= cfg_data;
        mme_pkg::REG_NUM_COLS:  num_cols  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows_c  = clamp_dim(num_rows);
  assign inner_c = clamp_dim(inner_len);
  assign cols_c  = clamp_dim(num_cols);

  assign k_last   = ({1'b0, k_cnt} == inner_c - mme_pkg::DIM_W'(1));
  assign row_last = ({1'b0, row_cnt} == rows_c - mme_pkg::DIM_W'(1));
  assign col_last = ({1'b0, col_cnt} == cols_c - mme_pkg::DIM_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mme_pkg::ST_IDLE;
      row_cnt <= '0;
      col_cnt <= '0;
      k_cnt   <= '0;
      a_base  <= '0;
      b_base  <= '0;
    end else begin
      state   <= state_next;
      row_cnt <= row_cnt_next;
      col_cnt <= col_cnt_next;
      k_cnt   <= k_cnt_next;
      a_base  <= a_base_next;
      b_base  <= b_base_next;
    end
  end

  always_comb begin
    state_next   = state;
    row_cnt_next = row_cnt;
    col_cnt_next = col_cnt;
    k_cnt_next   = k_cnt;
    a_base_next  = a_base;
    b_base_next  = b_base;
    in_ready     = 1'b0;

    cmd          = '0;
    cmd.first    = (k_cnt == '0);
    cmd.last     = k_last;
    cmd.a_addr   = a_base + mme_pkg::IDX_W'(k_cnt);
    cmd.b_addr   = b_base + mme_pkg::IDX_W'(k_cnt);
    cmd.row      = row_cnt;
    cmd.col      = col_cnt;
    cmd.is_last  = row_last && col_last;

    unique case (state)
      mme_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_accept && (command == mme_pkg::CMD_START)) begin
          state_next   = mme_pkg::ST_ISSUE;
          row_cnt_next = '0;
          col_cnt_next = '0;
          k_cnt_next   = '0;
          a_base_next  = '0;
          b_base_next  = '0;
        end
      end
      mme_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (k_last) begin
          k_cnt_next = '0;
          state_next = mme_pkg::ST_DRAIN;
        end else begin
          k_cnt_next = k_cnt + mme_pkg::POS_W'(1);
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (status.acc_done && status.out_free) begin
          cmd.load_out = 1'b1;
          if (row_last && col_last) begin
            state_next = mme_pkg::ST_IDLE;
          end else begin
            state_next = mme_pkg::ST_ISSUE;
            if (col_last) begin
              col_cnt_next = '0;
              b_base_next  = '0;
              row_cnt_next = row_cnt + mme_pkg::POS_W'(1);
              a_base_next  = a_base + mme_pkg::IDX_W'(inner_c);
            end else begin
              col_cnt_next = col_cnt + mme_pkg::POS_W'(1);
              b_base_next  = b_base + mme_pkg::IDX_W'(inner_c);
            end
          end
        end
      end
      default: state_next = mme_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/mme_dp.sv @@
// datapath: element stores, multiply-accumulate pipeline and result register
`default_nettype none

module mme_dp #(
  parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_accept,
  input  logic [mme_pkg::CMD_W-1:0]     command,
  input  logic [mme_pkg::IDX_W-1:0]     elem_index,
  input  logic signed [ELEM_WIDTH-1:0]  elem_value,
  input  mme_pkg::dp_cmd_t              cmd,
  output mme_pkg::dp_status_t           status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [mme_pkg::PROD_W-1:0] product_value,
  output logic [mme_pkg::POS_W-1:0]     out_row,
  output logic [mme_pkg::POS_W-1:0]     out_col,
  output logic                          is_last
);

  localparam int Depth  = MAX_DIM * MAX_DIM;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int MulW   = 2 * ELEM_WIDTH;

  logic signed [ELEM_WIDTH-1:0] a_mem [Depth];
  logic signed [ELEM_WIDTH-1:0] b_mem [Depth];

  logic                  idx_ok;
  logic                  wr_a, wr_b;
  logic [AddrW-1:0]      wr_addr;

  logic signed [ELEM_WIDTH-1:0] a_q, b_q;
  logic                  rd_valid, rd_first, rd_last;
  logic signed [MulW-1:0] prod;
  logic                  mul_valid, mul_first, mul_last;
  logic signed [mme_pkg::PROD_W-1:0] acc;
  logic signed [mme_pkg::PROD_W-1:0] prod_ext;
  logic                  acc_done;

  assign idx_ok  = ({1'b0, elem_index} < (mme_pkg::IDX_W + 1)'(Depth));
  assign wr_addr = elem_index[AddrW-1:0];
  assign wr_a    = in_accept && idx_ok && (command == mme_pkg::CMD_WR_A);
  assign wr_b    = in_accept && idx_ok && (command == mme_pkg::CMD_WR_B);

  // stores: one write port from the input, one registered read port for the mac
  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_addr] <= elem_value;
    end
    if (cmd.issue) begin
      a_q <= a_mem[cmd.a_addr[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_mem[wr_addr] <= elem_value;
    end
    if (cmd.issue) begin
      b_q <= b_mem[cmd.b_addr[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
      acc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid  <= cmd.issue;
      mul_valid <= rd_valid;
      if (mul_valid && mul_last) begin
        acc_done <= 1'b1;
      end else if (cmd.load_out) begin
        acc_done <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // tags follow the operands down the pipe
  always_ff @(posedge clk) begin
    rd_first  <= cmd.first;
    rd_last   <= cmd.last;
    mul_first <= rd_first;
    mul_last  <= rd_last;
    prod      <= a_q * b_q;
  end

  assign prod_ext = mme_pkg::PROD_W'(prod);

  always_ff @(posedge clk) begin
    if (mul_valid) begin
      acc <= mul_first ? prod_ext : acc + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      product_value <= acc;
      out_row       <= cmd.row;
      out_col       <= cmd.col;
      is_last       <= cmd.is_last;
    end
  end

  assign status.acc_done = acc_done;
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ hdl/matrix_multiply_engine_unit.sv @@
// top level of the matrix multiply engine: stream ports, controller and datapath
`default_nettype none

// Dense matrix multiply C = A x B on signed Q8.8 elements with exact Q19.16
// sums. A is held row-major (element row*inner_len+k), B column-major
// (element col*inner_len+k). Each input word is a command: write an A
// element, write a B element, or start. After a write the block takes the
// next word straight away; an index past the store is dropped, and an
// unused command code does nothing. A start runs the whole product and the
// block accepts no further word until the last result has been handed to
// the output register. Results leave in row-major order with tlast on the
// final one. One multiply-accumulate unit does all the work: each result
// takes inner_len reads of the two stores, then the read, multiply and
// accumulate stages draining, and a start also waits on any stall on the
// output. The output register holds one finished result while the next is
// computed. Dimension registers read as 1 when zero and as MAX_DIM when
// larger; the user must see that they are written through the cfg channel
// only while the block is idle, as the block itself does not enforce it.
// Store entries are undefined until written.

module matrix_multiply_engine_unit #(
  parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // command, elem_index, elem_value, zero fill
  input  logic [((mme_pkg::CMD_W + mme_pkg::IDX_W + ELEM_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // product_value, out_row, out_col, zero fill
  output logic [mme_pkg::OUT_W-1:0]           m_tdata,
  // is_last
  output logic                                m_tlast,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mme_pkg::REG_W-1:0]           cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]           cfg_data
);

  localparam int IdxLo = mme_pkg::CMD_W;
  localparam int ValLo = mme_pkg::CMD_W + mme_pkg::IDX_W;
  localparam int RowLo = mme_pkg::PROD_W;
  localparam int ColLo = mme_pkg::PROD_W + mme_pkg::POS_W;
  localparam int PadLo = mme_pkg::PROD_W + 2 * mme_pkg::POS_W;

  // unpacked input word
  logic                                 in_accept;
  logic [mme_pkg::CMD_W-1:0]            command;
  logic [mme_pkg::IDX_W-1:0]            elem_index;
  logic signed [ELEM_WIDTH-1:0]         elem_value;

  // result fields from the output register
  logic signed [mme_pkg::PROD_W-1:0]    product_value;
  logic [mme_pkg::POS_W-1:0]            out_row;
  logic [mme_pkg::POS_W-1:0]            out_col;
  logic                                 is_last;

  mme_pkg::dp_cmd_t                     dp_cmd;
  mme_pkg::dp_status_t                  dp_status;

  assign in_accept  = s_tvalid && s_tready;
  assign command    = s_tdata[IdxLo-1:0];
  assign elem_index = s_tdata[ValLo-1:IdxLo];
  assign elem_value = s_tdata[ValLo+ELEM_WIDTH-1:ValLo];

  // sequencing: config registers, loop counters, state machine
  mme_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .command   (command),
    .in_ready  (s_tready),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

  // stores, mac pipeline and result register
  mme_dp #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_accept     (in_accept),
    .command       (command),
    .elem_index    (elem_index),
    .elem_value    (elem_value),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .is_last       (is_last)
  );

  // pack the result word, padding to whole bytes
  assign m_tdata[RowLo-1:0]          = product_value;
  assign m_tdata[ColLo-1:RowLo]      = out_row;
  assign m_tdata[PadLo-1:ColLo]      = out_col;
  assign m_tdata[mme_pkg::OUT_W-1:PadLo] = '0;
  assign m_tlast                     = is_last;

endmodule

`default_nettype wire

@@ hdl/mme_check.sv @@
// port-level checker for the matrix multiply engine, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module mme_check #(
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [((mme_pkg::CMD_W + mme_pkg::IDX_W + ELEM_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [mme_pkg::OUT_W-1:0]           m_tdata,
  input  logic                                m_tlast
);

  logic start_acc, write_acc;
  logic out_stall;
  logic [mme_pkg::OUT_W:0] out_word;

  assign start_acc = s_tvalid && s_tready &&
                     (s_tdata[mme_pkg::CMD_W-1:0] == mme_pkg::CMD_START);
  assign write_acc = s_tvalid && s_tready &&
                     ((s_tdata[mme_pkg::CMD_W-1:0] == mme_pkg::CMD_WR_A) ||
                      (s_tdata[mme_pkg::CMD_W-1:0] == mme_pkg::CMD_WR_B));

  // result word and tlast seen as one
  assign out_stall = m_tvalid && !m_tready;
  assign out_word  = {m_tlast, m_tdata};

  // a stalled result word holds
  `ASSERT_RST(a_out_hold, clk, rst, out_stall |=> m_tvalid && $stable(out_word), "result changed")

  // a start takes the block busy
  `ASSERT_RST(a_start_busy, clk, rst, start_acc |=> !s_tready, "input still taken after start")

  // element writes leave the block ready for the next word
  `ASSERT_RST(a_write_ready, clk, rst, write_acc |=> s_tready, "block went busy on an element write")

  // reset leaves the block idle with nothing to send
  `ASSERT_ALL(a_reset_idle, clk, rst |=> s_tready && !m_tvalid, "block not idle after reset")

endmodule

bind matrix_multiply_engine_unit mme_check #(
  .ELEM_WIDTH (ELEM_WIDTH)
) u_mme_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
